/* rtl/sls_pkg.sv */
// sls_pkg: shared types and constants for the script lexer stream
// no dependencies
package sls_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 20;
    localparam int LENGTH_BITS = 16;

    // scanner modes
    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_IDENT = 4'd1;
    localparam logic [3:0] M_INT   = 4'd2;
    localparam logic [3:0] M_FRAC  = 4'd3;
    localparam logic [3:0] M_STR   = 4'd4;
    localparam logic [3:0] M_CMT   = 4'd5;
    localparam logic [3:0] M_SLASH = 4'd6;
    localparam logic [3:0] M_BANG  = 4'd7;
    localparam logic [3:0] M_EQ    = 4'd8;
    localparam logic [3:0] M_LT    = 4'd9;
    localparam logic [3:0] M_GT    = 4'd10;

    // token kinds
    localparam logic [5:0] K_LPAREN = 6'd0;
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACE = 6'd2;
    localparam logic [5:0] K_RBRACE = 6'd3;
    localparam logic [5:0] K_COMMA  = 6'd4;
    localparam logic [5:0] K_DOT    = 6'd5;
    localparam logic [5:0] K_MINUS  = 6'd6;
    localparam logic [5:0] K_PLUS   = 6'd7;
    localparam logic [5:0] K_SEMI   = 6'd8;
    localparam logic [5:0] K_SLASH  = 6'd9;
    localparam logic [5:0] K_STAR   = 6'd10;
    localparam logic [5:0] K_BANG   = 6'd11;
    localparam logic [5:0] K_EQ     = 6'd13;
    localparam logic [5:0] K_GT     = 6'd15;
    localparam logic [5:0] K_LT     = 6'd17;
    localparam logic [5:0] K_IDENT  = 6'd19;
    localparam logic [5:0] K_STRING = 6'd20;
    localparam logic [5:0] K_NUMBER = 6'd21;
    localparam logic [5:0] K_AND    = 6'd22;
    localparam logic [5:0] K_CLASS  = 6'd23;
    localparam logic [5:0] K_ELSE   = 6'd24;
    localparam logic [5:0] K_FALSE  = 6'd25;
    localparam logic [5:0] K_FOR    = 6'd26;
    localparam logic [5:0] K_FUN    = 6'd27;
    localparam logic [5:0] K_IF     = 6'd28;
    localparam logic [5:0] K_NIL    = 6'd29;
    localparam logic [5:0] K_OR     = 6'd30;
    localparam logic [5:0] K_PRINT  = 6'd31;
    localparam logic [5:0] K_RETURN = 6'd32;
    localparam logic [5:0] K_SUPER  = 6'd33;
    localparam logic [5:0] K_THIS   = 6'd34;
    localparam logic [5:0] K_TRUE   = 6'd35;
    localparam logic [5:0] K_VAR    = 6'd36;
    localparam logic [5:0] K_WHILE  = 6'd37;
    localparam logic [5:0] K_ERROR  = 6'd38;
    localparam logic [5:0] K_END    = 6'd39;

    // error codes
    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_CHAR  = 2'd1;
    localparam logic [1:0] E_UNTERM = 2'd2;

    typedef struct packed {
        logic [5:0]             kind;
        logic [1:0]             err;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
    } token_t;

    // up to three tokens from one item, oldest in slot 0
    typedef struct packed {
        logic [1:0] count;
        token_t     t2;
        token_t     t1;
        token_t     t0;
    } tok_group_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

endpackage

/* rtl/sls_keyword.sv */
// sls_keyword: keyword lookup over the stored identifier prefix
// depends on sls_pkg
module sls_keyword
    import sls_pkg::*;
(
    input  logic [47:0]            prefix,
    input  logic [LENGTH_BITS-1:0] run_len,
    output logic [5:0]             word_kind
);
    logic [7:0] p0, p1, p2, p3, p4, p5;

    assign p0 = prefix[7:0];
    assign p1 = prefix[15:8];
    assign p2 = prefix[23:16];
    assign p3 = prefix[31:24];
    assign p4 = prefix[39:32];
    assign p5 = prefix[47:40];

    // compare against each keyword at its exact length
    always_comb begin
        word_kind = K_IDENT;
        if (run_len == LENGTH_BITS'(2)) begin
            if (p0 == "i" && p1 == "f") word_kind = K_IF;
            if (p0 == "o" && p1 == "r") word_kind = K_OR;
        end else if (run_len == LENGTH_BITS'(3)) begin
            if (p0 == "a" && p1 == "n" && p2 == "d") word_kind = K_AND;
            if (p0 == "f" && p1 == "o" && p2 == "r") word_kind = K_FOR;
            if (p0 == "f" && p1 == "u" && p2 == "n") word_kind = K_FUN;
            if (p0 == "n" && p1 == "i" && p2 == "l") word_kind = K_NIL;
            if (p0 == "v" && p1 == "a" && p2 == "r") word_kind = K_VAR;
        end else if (run_len == LENGTH_BITS'(4)) begin
            if (p0 == "e" && p1 == "l" && p2 == "s" && p3 == "e") word_kind = K_ELSE;
            if (p0 == "t" && p1 == "h" && p2 == "i" && p3 == "s") word_kind = K_THIS;
            if (p0 == "t" && p1 == "r" && p2 == "u" && p3 == "e") word_kind = K_TRUE;
        end else if (run_len == LENGTH_BITS'(5)) begin
            if (p0 == "c" && p1 == "l" && p2 == "a" && p3 == "s" && p4 == "s")
                word_kind = K_CLASS;
            if (p0 == "f" && p1 == "a" && p2 == "l" && p3 == "s" && p4 == "e")
                word_kind = K_FALSE;
            if (p0 == "p" && p1 == "r" && p2 == "i" && p3 == "n" && p4 == "t")
                word_kind = K_PRINT;
            if (p0 == "s" && p1 == "u" && p2 == "p" && p3 == "e" && p4 == "r")
                word_kind = K_SUPER;
            if (p0 == "w" && p1 == "h" && p2 == "i" && p3 == "l" && p4 == "e")
                word_kind = K_WHILE;
        end else if (run_len == LENGTH_BITS'(6)) begin
            if (p0 == "r" && p1 == "e" && p2 == "t" && p3 == "u" && p4 == "r"
                && p5 == "n")
                word_kind = K_RETURN;
        end
    end
endmodule

/* rtl/sls_core.sv */
// sls_core: scanner state and per-item token generation, one item a cycle while step is high
// depends on sls_pkg and sls_keyword
module sls_core
    import sls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       in_end,
    input  logic [7:0] in_byte,
    output tok_group_t toks
);
    logic [3:0]             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [47:0]            prefix_reg, prefix_next;
    logic                   dot_reg, dot_next;
    logic [5:0]             word_kind;

    sls_keyword u_kw (
        .prefix   (prefix_reg),
        .run_len  (len_reg),
        .word_kind(word_kind)
    );

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    // next-state and token logic
    always_comb begin
        token_t     tk;
        logic [1:0] n;
        logic       rescan;
        logic [LINE_BITS-1:0] line_pre;
        logic [5:0] single;
        logic [7:0] c;
        logic [LENGTH_BITS:0] inc1, inc2;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        dot_next    = dot_reg;
        toks        = '0;
        n           = 2'd0;
        rescan      = 1'b0;
        c           = in_byte;
        single      = K_ERROR;
        tk          = '0;
        line_pre    = line_reg;
        inc1 = {1'b0, len_reg} + (LENGTH_BITS+1)'(1);
        inc2 = {1'b0, len_reg} + (LENGTH_BITS+1)'(2);

        // pending-token flush (used both on end and on a closing byte)
        if (in_end || !((mode_reg == M_IDENT && (is_alpha(c) || is_digit(c)))
                || (mode_reg == M_INT && dot_reg && is_digit(c))
                || (mode_reg == M_INT && !dot_reg && (is_digit(c) || c == "."))
                || (mode_reg == M_FRAC && is_digit(c))
                || (mode_reg == M_STR)
                || (mode_reg == M_CMT && c != 8'h0A)
                || (mode_reg == M_SLASH && c == "/")
                || ((mode_reg == M_BANG || mode_reg == M_EQ || mode_reg == M_LT
                     || mode_reg == M_GT) && c == "="))) begin
            rescan = ~in_end;
        end

        if (!in_end && !rescan) begin
            // byte continues the current token
            unique case (mode_reg)
                M_IDENT: begin
                    if (len_reg < LENGTH_BITS'(6))
                        prefix_next[len_reg[2:0]*8 +: 8] = c;
                    len_next = inc1[LENGTH_BITS] ? LEN_MAX : inc1[LENGTH_BITS-1:0];
                end
                M_INT: begin
                    if (dot_reg) begin
                        len_next = inc2[LENGTH_BITS] ? LEN_MAX : inc2[LENGTH_BITS-1:0];
                        dot_next = 1'b0;
                        mode_next = M_FRAC;
                    end else if (is_digit(c)) begin
                        len_next = inc1[LENGTH_BITS] ? LEN_MAX : inc1[LENGTH_BITS-1:0];
                    end else begin
                        dot_next = 1'b1;
                    end
                end
                M_FRAC: len_next = inc1[LENGTH_BITS] ? LEN_MAX : inc1[LENGTH_BITS-1:0];
                M_STR: begin
                    len_next = inc1[LENGTH_BITS] ? LEN_MAX : inc1[LENGTH_BITS-1:0];
                    if (c == 8'h0A && line_reg != LINE_MAX)
                        line_next = line_reg + LINE_BITS'(1);
                    if (c == 8'h22) begin
                        tk = '{K_STRING, E_NONE, start_reg, len_next, line_next};
                        toks.t0 = tk;
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_CMT: ;
                M_SLASH: mode_next = M_CMT;
                M_BANG, M_EQ, M_LT, M_GT: begin
                    unique case (mode_reg)
                        M_BANG:  single = K_BANG;
                        M_EQ:    single = K_EQ;
                        M_LT:    single = K_LT;
                        default: single = K_GT;
                    endcase
                    toks.t0 = '{single + 6'd1, E_NONE, start_reg,
                                LENGTH_BITS'(2), line_reg};
                    n = 2'd1;
                    mode_next = M_IDLE;
                end
                default: ;
            endcase
        end else begin
            // flush the pending token
            unique case (mode_reg)
                M_IDENT: begin
                    toks.t0 = '{word_kind, E_NONE, start_reg, len_reg, line_reg};
                    n = 2'd1;
                end
                M_INT, M_FRAC: begin
                    toks.t0 = '{K_NUMBER, E_NONE, start_reg, len_reg, line_reg};
                    n = 2'd1;
                    if (dot_reg) begin
                        toks.t1 = '{K_DOT, E_NONE, pos_reg - OFFSET_BITS'(1),
                                    LENGTH_BITS'(1), line_reg};
                        n = 2'd2;
                    end
                end
                M_STR: begin
                    toks.t0 = '{K_ERROR, E_UNTERM, start_reg, len_reg, line_reg};
                    n = 2'd1;
                end
                M_SLASH: begin
                    toks.t0 = '{K_SLASH, E_NONE, start_reg, LENGTH_BITS'(1), line_reg};
                    n = 2'd1;
                end
                M_BANG, M_EQ, M_LT, M_GT: begin
                    unique case (mode_reg)
                        M_BANG:  single = K_BANG;
                        M_EQ:    single = K_EQ;
                        M_LT:    single = K_LT;
                        default: single = K_GT;
                    endcase
                    toks.t0 = '{single, E_NONE, start_reg, LENGTH_BITS'(1), line_reg};
                    n = 2'd1;
                end
                default: ;
            endcase
            dot_next  = 1'b0;
            mode_next = M_IDLE;

            if (in_end) begin
                tk = '{K_END, E_NONE, pos_reg, '0, line_reg};
                mode_next  = M_IDLE;
                pos_next   = '0;
                start_next = '0;
                len_next   = '0;
                line_next  = LINE_BITS'(1);
            end else begin
                // scan the byte from idle
                tk = '0;
                tk.start = pos_reg;
                tk.len   = LENGTH_BITS'(1);
                tk.line  = line_pre;
                tk.err   = E_NONE;
                tk.kind  = 6'h3F;
                if (c == " " || c == 8'h0D || c == 8'h09) begin
                    tk.kind = 6'h3F;
                end else if (c == 8'h0A) begin
                    if (line_reg != LINE_MAX) line_next = line_reg + LINE_BITS'(1);
                end else if (is_alpha(c) || is_digit(c) || c == 8'h22 || c == "/"
                             || c == "!" || c == "=" || c == "<" || c == ">") begin
                    mode_next = is_alpha(c) ? M_IDENT : is_digit(c) ? M_INT
                              : c == 8'h22 ? M_STR : c == "/" ? M_SLASH
                              : c == "!" ? M_BANG : c == "=" ? M_EQ
                              : c == "<" ? M_LT : M_GT;
                    start_next = pos_reg;
                    len_next   = LENGTH_BITS'(1);
                    prefix_next[7:0] = c;
                end else begin
                    priority case (c)
                        "(": tk.kind = K_LPAREN;
                        ")": tk.kind = K_RPAREN;
                        "{": tk.kind = K_LBRACE;
                        "}": tk.kind = K_RBRACE;
                        ",": tk.kind = K_COMMA;
                        ".": tk.kind = K_DOT;
                        "-": tk.kind = K_MINUS;
                        "+": tk.kind = K_PLUS;
                        ";": tk.kind = K_SEMI;
                        "*": tk.kind = K_STAR;
                        default: begin
                            tk.kind = K_ERROR;
                            tk.err  = E_CHAR;
                        end
                    endcase
                end
            end

            // append the trailing token after the flushed ones
            if (tk.kind != 6'h3F) begin
                unique case (n)
                    2'd0:    toks.t0 = tk;
                    2'd1:    toks.t1 = tk;
                    default: toks.t2 = tk;
                endcase
                n = n + 2'd1;
            end
        end

        if (!in_end) pos_next = pos_reg + OFFSET_BITS'(1);
        toks.count = n;
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            dot_reg   <= 1'b0;
        end else if (step) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            dot_reg   <= dot_next;
        end
    end

    // identifier prefix bytes, no reset needed
    always_ff @(posedge aclk) begin
        if (step) prefix_reg <= prefix_next;
    end
endmodule

/* rtl/sls_out_queue.sv */
// sls_out_queue: holds up to three tokens of one item and serialises them
// depends on sls_pkg
module sls_out_queue
    import sls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  tok_group_t grp,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_ready,
    output token_t     out_tok,
    output logic       out_last
);
    token_t     slot_reg [3];
    logic [1:0] cnt_reg, idx_reg;
    logic       take;

    assign out_valid = (cnt_reg != 2'd0);
    assign take      = out_valid && out_ready;
    assign out_tok   = slot_reg[idx_reg];
    assign out_last  = (idx_reg + 2'd1 == cnt_reg);
    // accept when empty or when the final token of the group leaves now
    assign can_load  = !out_valid || (take && out_last);

    // slot pointer and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= grp.count;
            idx_reg <= 2'd0;
        end else if (take) begin
            if (out_last) begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // token payload
    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg[0] <= grp.t0;
            slot_reg[1] <= grp.t1;
            slot_reg[2] <= grp.t2;
        end
    end
endmodule

/* rtl/script_lexer_stream.sv */
// script_lexer_stream: top level of the streaming source scanner
// depends on sls_pkg, sls_core, sls_keyword and sls_out_queue
//
// channel   dir  payload
// s_axis    in   tdata = char_byte[7:0], tuser = kind
// m_axis    out  tdata = token fields, tlast = last
//
// one source item is taken per cycle while s_tready is high; its zero to three
// tokens go to the result register at the same edge and leave one per cycle
// while m_tready is high. s_tready stays low until the result queue is empty or
// its final token leaves. reset is synchronous on aresetn, low, and returns to
// offset 0, line 1, idle. a stall on m_axis holds s_tready low.
module script_lexer_stream
    import sls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte[7:0]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // token_kind[5:0], error_code[7:6],
                                   // start_offset[39:8], token_length[55:40],
                                   // line_number[75:56], zeros[79:76]
    output logic        m_tlast
);
    tok_group_t grp;
    token_t     tok;
    logic       can_load, step;

    assign s_tready = can_load;
    assign step     = s_tvalid && can_load;

    sls_core u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (step),
        .in_end (s_tuser),
        .in_byte(s_tdata),
        .toks   (grp)
    );

    sls_out_queue u_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .grp      (grp),
        .can_load (can_load),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_tok  (tok),
        .out_last (m_tlast)
    );

    // pack the token fields, lowest first
    assign m_tdata = {4'b0, tok.line, tok.len, tok.start, tok.err, tok.kind};
endmodule
